// ===== rtl/kmh_pkg.sv =====
`timescale 1ns / 1ps

package kmh_pkg;

    // element and list number widths, fixed by the port widths
    localparam int VALUE_BITS = 32;
    localparam int SRC_BITS   = 3;
    localparam int KIND_BITS  = 2;

    // transaction kinds
    localparam logic [KIND_BITS-1:0] KIND_HEAD   = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_START  = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_REFILL = 2'd2;
    localparam logic [KIND_BITS-1:0] KIND_NONE   = 2'd3;

    typedef logic signed [VALUE_BITS-1:0] value_t;
    typedef logic [SRC_BITS-1:0]          src_t;

    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        value_t               value;
        src_t                 list_id;
        logic                 more;
    } cmd_t;

    typedef struct packed {
        value_t merged_value;
        src_t   source_list;
        logic   finished;
    } result_t;

endpackage

// ===== rtl/kmh_front.sv =====
`timescale 1ns / 1ps

module kmh_front
    import kmh_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [KIND_BITS-1:0] kind,
    input  value_t               value,
    input  src_t                 list_id,
    input  logic                 more,
    output logic                 cmd_valid,
    output cmd_t                 cmd,
    input  logic                 cmd_take
);

    // two-entry command queue
    cmd_t       q_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic       enq;
    logic       deq;

    assign full      = (cnt_reg == 2'd2);
    // unused kind code is accepted and dropped here
    assign enq       = push && !full && (kind != KIND_NONE);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign deq       = cmd_valid && cmd_take;
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next    = cnt_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (enq)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (deq)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (enq && !deq)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (deq && !enq)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_reg[wr_ptr_reg] <= '{kind: kind, value: value, list_id: list_id, more: more};
        end
    end

endmodule

// ===== rtl/kmh_back.sv =====
`timescale 1ns / 1ps

module kmh_back
    import kmh_pkg::*;
#(
    parameter int LISTS = 8
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    input  cmd_t    cmd,
    output logic    cmd_take,
    output logic    res_valid,
    output result_t res,
    input  logic    res_pop
);

    localparam int IDX_W = $clog2(LISTS);
    localparam int CNT_W = $clog2(LISTS + 1);
    localparam int CH_W  = IDX_W + 2;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_RF_LD    = 3'd1;
    localparam logic [2:0] ST_BLD_RD   = 3'd2;
    localparam logic [2:0] ST_BLD_LD   = 3'd3;
    localparam logic [2:0] ST_SIFT_RD  = 3'd4;
    localparam logic [2:0] ST_SIFT_CMP = 3'd5;
    localparam logic [2:0] ST_ROOT_RD  = 3'd6;
    localparam logic [2:0] ST_EMIT     = 3'd7;

    // heap storage
    value_t mem_val [LISTS];
    src_t   mem_src [LISTS];

    logic [2:0]       st_reg, st_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             merging_reg, merging_next;
    logic [IDX_W-1:0] node_reg, node_next;
    logic [CNT_W-1:0] lim_reg, lim_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic             building_reg, building_next;
    logic             more_reg, more_next;
    value_t           cur_val_reg, cur_val_next;
    src_t             cur_src_reg, cur_src_next;
    logic             res_valid_reg, res_valid_next;
    result_t          res_reg;
    value_t           rda_val_reg, rdb_val_reg;
    src_t             rda_src_reg, rdb_src_reg;

    logic [IDX_W-1:0] addr_a, addr_b, waddr;
    logic             we;
    value_t           wval;
    src_t             wsrc;
    logic [CH_W-1:0]  lc, rc;
    logic             lc_ok, rc_ok, a_lt, b_lt;
    value_t           best_val;
    logic [CNT_W-1:0] cnt_m1;
    logic             out_free, res_load;
    result_t          res_new;

    assign lc       = {1'b0, node_reg, 1'b1};
    assign rc       = lc + CH_W'(1);
    assign lc_ok    = lc < CH_W'(lim_reg);
    assign rc_ok    = rc < CH_W'(lim_reg);
    assign a_lt     = lc_ok && (rda_val_reg < cur_val_reg);
    assign best_val = a_lt ? rda_val_reg : cur_val_reg;
    assign b_lt     = rc_ok && (rdb_val_reg < best_val);
    assign cnt_m1   = count_reg - CNT_W'(1);
    assign out_free = !res_valid_reg || res_pop;

    always_comb
    begin
        addr_a = '0;
        addr_b = '0;
        case (st_reg)
            ST_IDLE:
            begin
                if (!cmd.more && count_reg != '0)
                begin
                    addr_a = IDX_W'(cnt_m1);
                end
            end
            ST_BLD_RD:
            begin
                addr_a = IDX_W'(k_reg - CNT_W'(1));
            end
            ST_SIFT_RD:
            begin
                if (lc_ok)
                begin
                    addr_a = IDX_W'(lc);
                end
                if (rc_ok)
                begin
                    addr_b = IDX_W'(rc);
                end
            end
            default:
            begin
                addr_a = '0;
            end
        endcase
    end

    always_comb
    begin
        st_next        = st_reg;
        count_next     = count_reg;
        merging_next   = merging_reg;
        node_next      = node_reg;
        lim_next       = lim_reg;
        k_next         = k_reg;
        building_next  = building_reg;
        more_next      = more_reg;
        cur_val_next   = cur_val_reg;
        cur_src_next   = cur_src_reg;
        cmd_take       = 1'b0;
        we             = 1'b0;
        waddr          = node_reg;
        wval           = cur_val_reg;
        wsrc           = cur_src_reg;
        res_load       = 1'b0;
        res_new        = '{merged_value: rda_val_reg, source_list: rda_src_reg, finished: 1'b0};
        case (st_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_take = 1'b1;
                    case (cmd.kind)
                        KIND_HEAD:
                        begin
                            if (!merging_reg && count_reg < CNT_W'(LISTS))
                            begin
                                we         = 1'b1;
                                waddr      = IDX_W'(count_reg);
                                wval       = cmd.value;
                                wsrc       = cmd.list_id;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        KIND_START:
                        begin
                            if (!merging_reg)
                            begin
                                merging_next = 1'b1;
                                lim_next     = count_reg;
                                if ((count_reg >> 1) != '0)
                                begin
                                    k_next        = count_reg >> 1;
                                    building_next = 1'b1;
                                    st_next       = ST_BLD_RD;
                                end
                                else
                                begin
                                    st_next = ST_ROOT_RD;
                                end
                            end
                        end
                        KIND_REFILL:
                        begin
                            if (merging_reg && count_reg != '0)
                            begin
                                more_next    = cmd.more;
                                cur_val_next = cmd.value;
                                if (!cmd.more)
                                begin
                                    count_next = cnt_m1;
                                end
                                st_next = ST_RF_LD;
                            end
                        end
                        default:
                        begin
                            st_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RF_LD:
            begin
                // new element keeps the root's list, otherwise last entry moves up
                if (!more_reg)
                begin
                    cur_val_next = rda_val_reg;
                end
                cur_src_next = rda_src_reg;
                node_next    = '0;
                lim_next     = count_reg;
                st_next      = ST_SIFT_RD;
            end
            ST_BLD_RD:
            begin
                st_next = ST_BLD_LD;
            end
            ST_BLD_LD:
            begin
                cur_val_next = rda_val_reg;
                cur_src_next = rda_src_reg;
                node_next    = IDX_W'(k_reg - CNT_W'(1));
                st_next      = ST_SIFT_RD;
            end
            ST_SIFT_RD:
            begin
                st_next = ST_SIFT_CMP;
            end
            ST_SIFT_CMP:
            begin
                we = 1'b1;
                if (b_lt)
                begin
                    wval      = rdb_val_reg;
                    wsrc      = rdb_src_reg;
                    node_next = IDX_W'(rc);
                    st_next   = ST_SIFT_RD;
                end
                else if (a_lt)
                begin
                    wval      = rda_val_reg;
                    wsrc      = rda_src_reg;
                    node_next = IDX_W'(lc);
                    st_next   = ST_SIFT_RD;
                end
                else if (building_reg && k_reg != CNT_W'(1))
                begin
                    k_next  = k_reg - CNT_W'(1);
                    st_next = ST_BLD_RD;
                end
                else
                begin
                    building_next = 1'b0;
                    st_next       = ST_ROOT_RD;
                end
            end
            ST_ROOT_RD:
            begin
                st_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    res_load = 1'b1;
                    if (count_reg == '0)
                    begin
                        res_new      = '{merged_value: '0, source_list: '0, finished: 1'b1};
                        merging_next = 1'b0;
                    end
                    st_next = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_pop)
        begin
            res_valid_next = 1'b0;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            count_reg     <= '0;
            merging_reg   <= 1'b0;
            building_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            count_reg     <= count_next;
            merging_reg   <= merging_next;
            building_reg  <= building_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg    <= node_next;
        lim_reg     <= lim_next;
        k_reg       <= k_next;
        more_reg    <= more_next;
        cur_val_reg <= cur_val_next;
        cur_src_reg <= cur_src_next;
        if (res_load)
        begin
            res_reg <= res_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_val[waddr] <= wval;
            mem_src[waddr] <= wsrc;
        end
        rda_val_reg <= mem_val[addr_a];
        rda_src_reg <= mem_src[addr_a];
        rdb_val_reg <= mem_val[addr_b];
        rdb_src_reg <= mem_src[addr_b];
    end

endmodule

// ===== rtl/kway_merge_min_heap_top.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake           payload
// input     in         push / full         kind, value, list_id, more
// result    out        pop / empty         merged_value, source_list, finished
//
// a head transaction is written into the heap as it is taken; a refill loads the new root,
// then sifts it down one heap node at a time (the last one a leaf compare), then reads
// the root and emits it
// a start runs one sift per inner node (count/2 sifts for count heads loaded) before
// the root is emitted; each sift follows the single heap memory: two child reads then
// one compare and write per level
// reset is asynchronous, active low; it clears counts and flags, not heap contents
// a result waiting in the output register does not stop the command queue filling;
// the engine only halts when it has a result to emit and the register is still full

module kway_merge_min_heap_top
    import kmh_pkg::*;
#(
    parameter int LISTS = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [KIND_BITS-1:0] kind,
    input  value_t               value,
    input  src_t                 list_id,
    input  logic                 more,
    output logic                 empty,
    input  logic                 pop,
    output value_t               merged_value,
    output src_t                 source_list,
    output logic                 finished
);

    // command path between the front queue and the heap engine
    logic    cmd_valid;
    cmd_t    cmd;
    logic    cmd_take;
    logic    res_valid;
    result_t res;

    // front: takes transactions while not full, drops unused kinds, queues the rest
    kmh_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .kind      (kind),
        .value     (value),
        .list_id   (list_id),
        .more      (more),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    // back: heap memory, build / sift sequencer and output register
    kmh_back #(
        .LISTS (LISTS)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .res_valid (res_valid),
        .res       (res),
        .res_pop   (pop)
    );

    // result register drives the output side directly
    assign empty        = !res_valid;
    assign merged_value = res.merged_value;
    assign source_list  = res.source_list;
    assign finished     = res.finished;

endmodule

// ===== rtl/kmh_checker.sv =====
`timescale 1ns / 1ps

module kmh_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [31:0] merged_value,
    input logic [2:0]  source_list,
    input logic        finished
);

    // waiting result holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(merged_value) && $stable(source_list)
                              && $stable(finished)))
        else $error("result changed while waiting");

    // result only leaves through a pop
    a_leave: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(empty) |-> $past(pop))
        else $error("result dropped without pop");

    // finished result carries zero fields
    a_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && finished) |-> (merged_value == 32'd0 && source_list == 3'd0))
        else $error("finished result with nonzero fields");

    // command queue fills only on an accepted transaction
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push))
        else $error("queue full without push");

endmodule

bind kway_merge_min_heap_top kmh_checker u_kmh_checker (.*);
